[design/unix_time_calendar_convert_top_defines.svh]
// Assertion shorthands for the calendar converter.
// All of them sample on clk_i and are off while rst_ni is low.
`ifndef UNIX_TIME_CALENDAR_CONVERT_TOP_DEFINES_SVH
`define UNIX_TIME_CALENDAR_CONVERT_TOP_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define UTCC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define UTCC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/utcc_pkg.sv]
`timescale 1ns / 1ps
package utcc_pkg;

  localparam logic [31:0] Epoch2000   = 32'd946684800;
  localparam logic [16:0] SecsPerDay  = 17'd86400;
  localparam logic [11:0] SecsPerHour = 12'd3600;
  localparam logic [5:0]  SecsPerMin  = 6'd60;
  localparam logic [4:0]  HoursPerDay = 5'd24;
  localparam logic [2:0]  DaysPerWeek = 3'd7;
  localparam logic [10:0] DaysPerQuad = 11'd1461;
  localparam logic [8:0]  DaysLeap    = 9'd366;
  localparam logic [8:0]  DaysCommon  = 9'd365;
  localparam logic [3:0]  MonthFirst  = 4'd1;
  localparam logic [3:0]  MonthFeb    = 4'd2;
  localparam logic [3:0]  MonthLast   = 4'd12;
  localparam logic [2:0]  WdayEpoch   = 3'd6;  // 2000-01-01 was a Saturday
  localparam logic [2:0]  WdayD2sBias = 3'd5;
  localparam logic [5:0]  WdayQuad    = 6'd5;  // 1461 mod 7
  localparam logic [5:0]  WdayLeapYr  = 6'd2;  // 366 mod 7
  localparam logic [5:0]  WdayComYr   = 6'd1;  // 365 mod 7

  typedef struct packed {
    logic        command;
    logic [31:0] unix_seconds;
    logic [7:0]  year_offset;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } in_item_t;

  typedef struct packed {
    logic [31:0] out_seconds;
    logic [7:0]  out_year_offset;
    logic [3:0]  out_month;
    logic [4:0]  out_day;
    logic [4:0]  out_hour;
    logic [5:0]  out_minute;
    logic [5:0]  out_second;
    logic [2:0]  weekday;
  } out_item_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_DIV,
    OP_TAKE_SEC,
    OP_TAKE_MIN,
    OP_TAKE_HOUR,
    OP_QUAD,
    OP_YEAR,
    OP_MONTH,
    OP_FINISH_DATE,
    OP_DAYS,
    OP_MUL,
    OP_SUM,
    OP_TAKE_WDAY,
    OP_EMIT
  } dp_op_e;

  typedef enum logic [1:0] {
    DIV_60,
    DIV_24,
    DIV_7
  } div_sel_e;

  typedef struct packed {
    dp_op_e   op;
    div_sel_e div;
  } dp_cmd_t;

  typedef struct packed {
    logic quad_ge;
    logic year_ge;
    logic month_ge;
    logic month_last;
  } dp_status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV_SEC,
    S_TAKE_SEC,
    S_DIV_MIN,
    S_TAKE_MIN,
    S_DIV_HOUR,
    S_TAKE_HOUR,
    S_QUAD,
    S_YEAR,
    S_MONTH,
    S_DAYS,
    S_MUL,
    S_SUM,
    S_DIV_WDAY,
    S_TAKE_WDAY,
    S_DONE
  } ctrl_state_e;

  // Quotient by reciprocal: (x * mul) >> shift. Exact for any 32-bit x by 60
  // and by 24, and for x below 2^31 by 7.
  function automatic logic [31:0] recip_mul(input div_sel_e sel);
    logic [31:0] v;
    unique case (sel)
      DIV_60:  v = 32'h8888_8889;
      DIV_24:  v = 32'hAAAA_AAAB;
      DIV_7:   v = 32'h9249_2493;
      default: v = 32'h8888_8889;
    endcase
    return v;
  endfunction

  function automatic logic [5:0] recip_shift(input div_sel_e sel);
    logic [5:0] v;
    unique case (sel)
      DIV_60:  v = 6'd37;
      DIV_24:  v = 6'd36;
      DIV_7:   v = 6'd34;
      default: v = 6'd37;
    endcase
    return v;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] v;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: v = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                     v = 5'd30;
      4'd2:                                        v = 5'd28;
      default:                                     v = 5'd31;
    endcase
    return v;
  endfunction

  // Days in the months before month m; months past twelve count the full year.
  function automatic logic [8:0] cum_days(input logic [3:0] m);
    logic [8:0] v;
    unique case (m)
      4'd0, 4'd1: v = 9'd0;
      4'd2:       v = 9'd31;
      4'd3:       v = 9'd59;
      4'd4:       v = 9'd90;
      4'd5:       v = 9'd120;
      4'd6:       v = 9'd151;
      4'd7:       v = 9'd181;
      4'd8:       v = 9'd212;
      4'd9:       v = 9'd243;
      4'd10:      v = 9'd273;
      4'd11:      v = 9'd304;
      4'd12:      v = 9'd334;
      default:    v = 9'd365;
    endcase
    return v;
  endfunction

  // Valid for x below 42.
  function automatic logic [2:0] mod7(input logic [5:0] x);
    logic [5:0] v;
    v = x;
    for (int i = 0; i < 5; i++) begin
      if (v >= 6'd7) begin
        v = v - 6'd7;
      end
    end
    return v[2:0];
  endfunction

endpackage

[design/utcc_dp.sv]
`timescale 1ns / 1ps
module utcc_dp
  import utcc_pkg::*;
(
  input  logic       clk_i,
  input  in_item_t   in_data_i,
  input  dp_cmd_t    cmd_i,
  output dp_status_t status_o,
  output out_item_t  out_data_o
);

  logic [31:0] secs_q, secs_d;
  logic [7:0]  y_q, y_d;
  logic [3:0]  m_q, m_d;
  logic [4:0]  d_q, d_d;
  logic [4:0]  hh_q, hh_d;
  logic [5:0]  mi_q, mi_d;
  logic [5:0]  ss_q, ss_d;
  logic [2:0]  wd_q, wd_d;
  logic [31:0] quo_q, quo_d;
  logic [31:0] dvd_q, dvd_d;
  logic [16:0] days_q, days_d;
  logic [31:0] prod_q, prod_d;
  logic [16:0] hms_q, hms_d;
  out_item_t   out_q, out_d;

  logic [63:0] recip_prod;
  logic [31:0] div_quo;
  logic        leap;
  logic [8:0]  year_len;
  logic [5:0]  year_wd;
  logic [4:0]  mon_len;
  logic [16:0] n_days;

  assign recip_prod = 64'(quo_q) * 64'(recip_mul(cmd_i.div));
  assign div_quo    = 32'(recip_prod >> recip_shift(cmd_i.div));

  assign leap     = (y_q[1:0] == 2'd0);
  assign year_len = leap ? DaysLeap : DaysCommon;
  assign year_wd  = leap ? WdayLeapYr : WdayComYr;
  assign mon_len  = month_len(m_q) + {4'd0, (leap && (m_q == MonthFeb))};

  // Day count plus one, from the captured date fields.
  always_comb begin
    n_days = 17'(d_q) + 17'(cum_days(m_q))
           + 17'(((m_q > MonthFeb) && leap) ? 1 : 0)
           + 17'(y_q) * 17'(DaysCommon)
           + 17'((9'(y_q) + 9'd3) >> 2);
  end

  assign status_o.quad_ge    = days_q >= 17'(DaysPerQuad);
  assign status_o.year_ge    = days_q >= 17'(year_len);
  assign status_o.month_ge   = days_q >= 17'(mon_len);
  assign status_o.month_last = (m_q == MonthLast);

  always_comb begin
    secs_d = secs_q;
    y_d    = y_q;
    m_d    = m_q;
    d_d    = d_q;
    hh_d   = hh_q;
    mi_d   = mi_q;
    ss_d   = ss_q;
    wd_d   = wd_q;
    quo_d  = quo_q;
    dvd_d  = dvd_q;
    days_d = days_q;
    prod_d = prod_q;
    hms_d  = hms_q;
    out_d  = out_q;
    unique case (cmd_i.op)
      OP_NONE: begin
      end
      OP_LOAD: begin
        secs_d = in_data_i.unix_seconds;
        y_d    = in_data_i.year_offset;
        m_d    = in_data_i.month;
        d_d    = in_data_i.day;
        hh_d   = in_data_i.hour;
        mi_d   = in_data_i.minute;
        ss_d   = in_data_i.second;
        quo_d  = in_data_i.unix_seconds - Epoch2000;
      end
      OP_DIV: begin
        // keep the dividend for the remainder in the next cycle
        dvd_d = quo_q;
        quo_d = div_quo;
      end
      OP_TAKE_SEC: begin
        ss_d = 6'(dvd_q - quo_q * 32'(SecsPerMin));
      end
      OP_TAKE_MIN: begin
        mi_d = 6'(dvd_q - quo_q * 32'(SecsPerMin));
      end
      OP_TAKE_HOUR: begin
        hh_d   = 5'(dvd_q - quo_q * 32'(HoursPerDay));
        days_d = quo_q[16:0];
        y_d    = '0;
        m_d    = MonthFirst;
        wd_d   = WdayEpoch;
      end
      OP_QUAD: begin
        days_d = days_q - 17'(DaysPerQuad);
        y_d    = y_q + 8'd4;
        wd_d   = mod7({3'd0, wd_q} + WdayQuad);
      end
      OP_YEAR: begin
        days_d = days_q - 17'(year_len);
        y_d    = y_q + 8'd1;
        wd_d   = mod7({3'd0, wd_q} + year_wd);
      end
      OP_MONTH: begin
        days_d = days_q - 17'(mon_len);
        m_d    = m_q + 4'd1;
        wd_d   = mod7({3'd0, wd_q} + {1'b0, mon_len});
      end
      OP_FINISH_DATE: begin
        d_d  = days_q[4:0] + 5'd1;
        wd_d = mod7({3'd0, wd_q} + {1'b0, days_q[4:0]});
      end
      OP_DAYS: begin
        days_d = n_days;
      end
      OP_MUL: begin
        prod_d = 32'((32'(days_q) - 32'd1) * 32'(SecsPerDay));
        hms_d  = 17'(hh_q) * 17'(SecsPerHour) + 17'(mi_q) * 17'(SecsPerMin)
               + 17'(ss_q);
      end
      OP_SUM: begin
        secs_d = prod_q + 32'(hms_q) + Epoch2000;
        quo_d  = 32'(days_q) + 32'(WdayD2sBias);
      end
      OP_TAKE_WDAY: begin
        wd_d = 3'(dvd_q - quo_q * 32'(DaysPerWeek));
      end
      OP_EMIT: begin
        out_d.out_seconds     = secs_q;
        out_d.out_year_offset = y_q;
        out_d.out_month       = m_q;
        out_d.out_day         = d_q;
        out_d.out_hour        = hh_q;
        out_d.out_minute      = mi_q;
        out_d.out_second      = ss_q;
        out_d.weekday         = wd_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    secs_q <= secs_d;
    y_q    <= y_d;
    m_q    <= m_d;
    d_q    <= d_d;
    hh_q   <= hh_d;
    mi_q   <= mi_d;
    ss_q   <= ss_d;
    wd_q   <= wd_d;
    quo_q  <= quo_d;
    dvd_q  <= dvd_d;
    days_q <= days_d;
    prod_q <= prod_d;
    hms_q  <= hms_d;
    out_q  <= out_d;
  end

  assign out_data_o = out_q;

endmodule

[design/utcc_ctrl.sv]
`timescale 1ns / 1ps
module utcc_ctrl
  import utcc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_command_i,
  output logic       in_stall_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    cmd_o.op  = OP_NONE;
    cmd_o.div = DIV_60;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = in_command_i ? S_DAYS : S_DIV_SEC;
        end
      end
      S_DIV_SEC: begin
        cmd_o.op = OP_DIV;
        state_d  = S_TAKE_SEC;
      end
      S_TAKE_SEC: begin
        cmd_o.op = OP_TAKE_SEC;
        state_d  = S_DIV_MIN;
      end
      S_DIV_MIN: begin
        cmd_o.op = OP_DIV;
        state_d  = S_TAKE_MIN;
      end
      S_TAKE_MIN: begin
        cmd_o.op = OP_TAKE_MIN;
        state_d  = S_DIV_HOUR;
      end
      S_DIV_HOUR: begin
        cmd_o.op  = OP_DIV;
        cmd_o.div = DIV_24;
        state_d   = S_TAKE_HOUR;
      end
      S_TAKE_HOUR: begin
        cmd_o.op = OP_TAKE_HOUR;
        state_d  = S_QUAD;
      end
      S_QUAD: begin
        if (status_i.quad_ge) begin
          cmd_o.op = OP_QUAD;
        end else begin
          state_d = S_YEAR;
        end
      end
      S_YEAR: begin
        if (status_i.year_ge) begin
          cmd_o.op = OP_YEAR;
        end else begin
          state_d = S_MONTH;
        end
      end
      S_MONTH: begin
        if (status_i.month_ge && !status_i.month_last) begin
          cmd_o.op = OP_MONTH;
        end else begin
          cmd_o.op = OP_FINISH_DATE;
          state_d  = S_DONE;
        end
      end
      S_DAYS: begin
        cmd_o.op = OP_DAYS;
        state_d  = S_MUL;
      end
      S_MUL: begin
        cmd_o.op = OP_MUL;
        state_d  = S_SUM;
      end
      S_SUM: begin
        cmd_o.op = OP_SUM;
        state_d  = S_DIV_WDAY;
      end
      S_DIV_WDAY: begin
        cmd_o.op  = OP_DIV;
        cmd_o.div = DIV_7;
        state_d   = S_TAKE_WDAY;
      end
      S_TAKE_WDAY: begin
        cmd_o.op = OP_TAKE_WDAY;
        state_d  = S_DONE;
      end
      S_DONE: begin
        // hold the finished result until the output register frees up
        if (out_free) begin
          cmd_o.op    = OP_EMIT;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

[design/unix_time_calendar_convert_top.sv]
// Unix time <-> calendar converter, years counted from 2000.
// Input channel: in_valid_i / in_stall_o with an in_item_t beat. command 0
// decodes unix_seconds into a date, time and weekday; command 1 encodes the
// date and time fields into Unix seconds and a weekday and passes them through.
// Output channel: out_valid_o / out_stall_i with an out_item_t beat, one
// result beat per input beat, in order.
// One item is worked on at a time; in_stall_o is high from the accept until
// the result is handed to the output register.
// Seconds to date: three reciprocal-multiply divides (by 60, 60, 24), each
// a divide step then a remainder step, then a walk over 4-year blocks,
// single years and months.
// Date to seconds: day count, multiply, sum, divide by 7 for the weekday.
// The next beat can be accepted in the cycle after the result moves to the
// output register.
// The output register lets the next beat be accepted while a result waits;
// if the receiver still stalls when the next result is done, the block
// holds it and keeps in_stall_o high.
// Reset clears the controller and the output valid; no clearing pass.
`timescale 1ns / 1ps
`include "unix_time_calendar_convert_top_defines.svh"
module unix_time_calendar_convert_top
  import utcc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  utcc_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_command_i (in_data_i.command),
    .in_stall_o   (in_stall_o),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_i     (dp_status),
    .cmd_o        (dp_cmd)
  );

  utcc_dp u_dp (
    .clk_i      (clk_i),
    .in_data_i  (in_data_i),
    .cmd_i      (dp_cmd),
    .status_o   (dp_status),
    .out_data_o (out_data_o)
  );

  `UTCC_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o, "not busy after accept")
  `UTCC_ASSERT_SAME(a_load_on_accept, dp_cmd.op == OP_LOAD, in_valid_i && !in_stall_o, "load without accept")
  `UTCC_ASSERT_SAME(a_emit_output_free, dp_cmd.op == OP_EMIT, !out_valid_o || !out_stall_i, "result overwritten")
  `UTCC_ASSERT_SAME(a_weekday_range, out_valid_o, out_data_o.weekday != 3'd7, "weekday out of range")

endmodule

[verif/unix_time_calendar_convert_top_test.sv]
`timescale 1ns / 1ps

localparam logic [31:0] Y2kEpoch = 32'd946684800;
localparam logic [31:0] DaySeconds = 32'd86400;
localparam int unsigned MonthDays [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

class calendar_scoreboard;
  utcc_pkg::out_item_t pending_conversions[$];
  int unsigned mismatches;

  function new();
    mismatches = 0;
  endfunction

  function utcc_pkg::out_item_t convert_calendar(utcc_pkg::in_item_t req);
    utcc_pkg::out_item_t res;
    logic [31:0] t;
    logic [31:0] days;
    logic [31:0] total;
    logic [31:0] span;
    logic [31:0] n;
    logic [31:0] y;
    int unsigned yr;
    int unsigned mo;
    bit leap;
    res = '0;
    if (req.command == 1'b0) begin
      // wraps for timestamps before 2000
      t = req.unix_seconds - Y2kEpoch;
      res.out_second = 6'(t % 32'd60);
      t = t / 32'd60;
      res.out_minute = 6'(t % 32'd60);
      t = t / 32'd60;
      res.out_hour = 5'(t % 32'd24);
      days = t / 32'd24;
      total = days;
      yr = 0;
      leap = 1'b1;
      span = 32'd366;
      while (days >= span) begin
        days = days - span;
        yr++;
        leap = (yr % 4 == 0);
        span = leap ? 32'd366 : 32'd365;
      end
      // December takes whatever is left
      mo = 1;
      while (mo < 12) begin
        span = MonthDays[mo - 1] + ((leap && mo == 2) ? 32'd1 : 32'd0);
        if (days < span) break;
        days = days - span;
        mo++;
      end
      res.out_seconds = req.unix_seconds;
      res.out_year_offset = 8'(yr);
      res.out_month = 4'(mo);
      res.out_day = 5'(days + 32'd1);
      res.weekday = 3'((total + 32'd6) % 32'd7);
    end else begin
      y = 32'(req.year_offset);
      n = 32'(req.day);
      // months past twelve add the full table only
      for (int i = 1; i < int'(req.month) && i <= 12; i++) begin
        n = n + MonthDays[i - 1];
      end
      if (req.month > 4'd2 && req.year_offset[1:0] == 2'b00) n = n + 32'd1;
      n = n + 32'd365 * y + (y + 32'd3) / 32'd4;
      res.out_seconds = (n - 32'd1) * DaySeconds + 32'(req.hour) * 32'd3600
                        + 32'(req.minute) * 32'd60 + 32'(req.second) + Y2kEpoch;
      res.out_year_offset = req.year_offset;
      res.out_month = req.month;
      res.out_day = req.day;
      res.out_hour = req.hour;
      res.out_minute = req.minute;
      res.out_second = req.second;
      res.weekday = 3'((n + 32'd5) % 32'd7);
    end
    return res;
  endfunction

  function void note_request(utcc_pkg::in_item_t req);
    pending_conversions.push_back(convert_calendar(req));
  endfunction

  function void check_conversion(utcc_pkg::out_item_t got);
    utcc_pkg::out_item_t want;
    bit bad;
    if (pending_conversions.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("result beat with nothing pending: %0d %0d-%0d-%0d %0d:%0d:%0d wd%0d",
                 got.out_seconds, got.out_year_offset, got.out_month, got.out_day,
                 got.out_hour, got.out_minute, got.out_second, got.weekday);
      end
      return;
    end
    want = pending_conversions.pop_front();
    bad = (got.out_seconds !== want.out_seconds)
          || (got.out_year_offset !== want.out_year_offset)
          || (got.out_month !== want.out_month)
          || (got.out_day !== want.out_day)
          || (got.out_hour !== want.out_hour)
          || (got.out_minute !== want.out_minute)
          || (got.out_second !== want.out_second)
          || (got.weekday !== want.weekday);
    if (bad) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("conversion mismatch: expected %0d %0d-%0d-%0d %0d:%0d:%0d wd%0d",
                 want.out_seconds, want.out_year_offset, want.out_month, want.out_day,
                 want.out_hour, want.out_minute, want.out_second, want.weekday);
        $display("                     actual   %0d %0d-%0d-%0d %0d:%0d:%0d wd%0d",
                 got.out_seconds, got.out_year_offset, got.out_month, got.out_day,
                 got.out_hour, got.out_minute, got.out_second, got.weekday);
      end
    end
  endfunction
endclass

module unix_time_calendar_convert_top_test;
  import utcc_pkg::*;

  localparam int unsigned RandomRequests = 1700;
  localparam int unsigned LongHoldCycles = 1500;
  localparam int unsigned DrainCycles = 300;
  localparam int unsigned CycleLimit = 1_200_000;

  typedef enum int unsigned {
    STALL_NEVER,
    STALL_LIGHT,
    STALL_HEAVY
  } stall_mode_e;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_item_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_data_o;

  calendar_scoreboard sb = new();
  int unsigned burst_left = 0;
  int unsigned cycle_count = 0;
  bit long_hold_req = 1'b0;

  unix_time_calendar_convert_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic in_item_t make_s2d(logic [31:0] secs);
    in_item_t req;
    req.command = 1'b0;
    req.unix_seconds = secs;
    req.year_offset = 8'($urandom);
    req.month = 4'($urandom);
    req.day = 5'($urandom);
    req.hour = 5'($urandom);
    req.minute = 6'($urandom);
    req.second = 6'($urandom);
    return req;
  endfunction

  function automatic in_item_t make_d2s(int unsigned yr, int unsigned mo, int unsigned dd,
                                        int unsigned hh, int unsigned mi, int unsigned ss);
    in_item_t req;
    req.command = 1'b1;
    req.unix_seconds = $urandom;
    req.year_offset = 8'(yr);
    req.month = 4'(mo);
    req.day = 5'(dd);
    req.hour = 5'(hh);
    req.minute = 6'(mi);
    req.second = 6'(ss);
    return req;
  endfunction

  task automatic send_request(in_item_t req);
    int unsigned gap;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i <= req;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(req);
    // bursts of back-to-back beats, then a gap of random length
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 170) : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
      end
    end
  endtask

  task automatic send_random_request();
    in_item_t req;
    in_item_t month_start;
    int unsigned pick;
    int unsigned yr;
    int unsigned mo;
    int unsigned last_day;
    pick = $urandom_range(0, 99);
    yr = $urandom_range(0, 136);
    mo = $urandom_range(1, 12);
    last_day = MonthDays[mo - 1] + ((mo == 2 && yr % 4 == 0) ? 1 : 0);
    if (pick < 35) begin
      req = make_s2d($urandom);
    end else if (pick < 50) begin
      // land right around a month or year boundary
      month_start = make_d2s($urandom_range(0, 135), mo, 1, 0, 0, 0);
      req = make_s2d(sb.convert_calendar(month_start).out_seconds - 32'd1
                     + 32'($urandom_range(0, 2)));
    end else if (pick < 88) begin
      req = make_d2s(yr, mo, $urandom_range(1, last_day), $urandom_range(0, 23),
                     $urandom_range(0, 59), $urandom_range(0, 59));
    end else begin
      // any field value, out of range ones included
      req = make_d2s($urandom_range(0, 255), $urandom_range(0, 15), $urandom_range(0, 31),
                     $urandom_range(0, 31), $urandom_range(0, 63), $urandom_range(0, 63));
    end
    send_request(req);
  endtask

  initial begin : receiver
    stall_mode_e mode;
    int unsigned stretch;
    @(posedge rst_ni);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        repeat (LongHoldCycles) begin
          @(negedge clk_i);
          out_stall_i <= 1'b1;
        end
      end
      mode = stall_mode_e'($urandom_range(0, 2));
      stretch = $urandom_range(20, 300);
      repeat (stretch) begin
        @(negedge clk_i);
        case (mode)
          STALL_NEVER: out_stall_i <= 1'b0;
          STALL_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
          default:     out_stall_i <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_conversion(out_data_o);
  end

  initial begin : watchdog
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("unix_time_calendar_convert_top regression: fail");
    $finish;
  end

  initial begin : stimulus
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // seconds to date: extremes, epoch, pre-2000 wrap, leap days
    send_request(make_s2d(32'd0));
    send_request(make_s2d(32'hFFFF_FFFF));
    send_request(make_s2d(Y2kEpoch));
    send_request(make_s2d(Y2kEpoch - 32'd1));
    send_request(make_s2d(32'd951782400));
    send_request(make_s2d(32'd978307199));
    send_request(make_s2d(32'd4102444799));
    send_request(make_s2d(32'd4107542400));
    // date to seconds: in range, wrap, all ones, month zero/one/past twelve, day zero
    send_request(make_d2s(0, 1, 1, 0, 0, 0));
    send_request(make_d2s(136, 2, 7, 6, 28, 15));
    send_request(make_d2s(136, 12, 31, 23, 59, 59));
    send_request(make_d2s(255, 15, 31, 31, 63, 63));
    send_request(make_d2s(0, 0, 0, 0, 0, 0));
    send_request(make_d2s(4, 0, 15, 8, 30, 0));
    send_request(make_d2s(4, 2, 29, 12, 0, 0));
    send_request(make_d2s(100, 3, 1, 0, 0, 0));
    send_request(make_d2s(3, 13, 1, 0, 0, 0));
    send_request(make_d2s(8, 14, 0, 5, 6, 7));
    send_request(make_d2s(20, 6, 0, 0, 0, 0));
    send_request(make_d2s(0, 1, 31, 24, 60, 60));

    long_hold_req = 1'b1;
    repeat (RandomRequests) send_random_request();
    @(negedge clk_i);
    in_valid_i <= 1'b0;

    while (sb.pending_conversions.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending_conversions.size() == 0) begin
      $display("unix_time_calendar_convert_top regression: pass");
    end else begin
      $display("unix_time_calendar_convert_top regression: fail");
    end
    $finish;
  end
endmodule

[files.f]
+incdir+design
design/utcc_pkg.sv
design/utcc_dp.sv
design/utcc_ctrl.sv
design/unix_time_calendar_convert_top.sv
verif/unix_time_calendar_convert_top_test.sv
